>>> design/sdc_pkg.sv
// Shared constants, codes and types of the sector disk controller.
// No dependencies; imported by the top level and by sdc_check.
`timescale 1ns / 1ps
`default_nettype none

package sdc_pkg;

  localparam int SECTOR_BYTES      = 128;
  localparam int SECTORS_PER_DRIVE = 256;
  localparam int NUM_DRIVES        = 4;

  localparam int IDX_W    = $clog2(SECTOR_BYTES);
  localparam int BI_W     = IDX_W + 1;
  localparam int LBA_W    = (SECTORS_PER_DRIVE > 1) ? $clog2(SECTORS_PER_DRIVE) : 1;
  localparam int DRV_W    = $clog2(NUM_DRIVES);
  localparam int STORE_AW = DRV_W + LBA_W + IDX_W;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int BUF_DEPTH   = 1 << IDX_W;

  localparam logic [7:0] FILL_BYTE = 8'hE5;
  localparam logic [7:0] ST_READY  = 8'h01;
  localparam logic [7:0] ST_ERR    = 8'h02;
  localparam logic [7:0] ST_DRQ    = 8'h80;
  localparam logic [7:0] NO_DATA   = 8'hFF;
  localparam logic [7:0] DRIVE_MASK = 8'h03;

  localparam logic [7:0] CMD_READ  = 8'h01;
  localparam logic [7:0] CMD_WRITE = 8'h02;

  // register offsets inside the port window
  localparam logic [2:0] REG_CMD    = 3'd0;
  localparam logic [2:0] REG_STATUS = 3'd1;
  localparam logic [2:0] REG_LBA0   = 3'd2;
  localparam logic [2:0] REG_LBA1   = 3'd3;
  localparam logic [2:0] REG_LBA2   = 3'd4;
  localparam logic [2:0] REG_LBA3   = 3'd5;
  localparam logic [2:0] REG_DATA   = 3'd6;
  localparam logic [2:0] REG_DRIVE  = 3'd7;

  // configuration register indexes
  localparam logic [2:0] CFG_WIN_BASE = 3'd0;
  localparam logic [2:0] CFG_ATTACHED = 3'd1;
  localparam logic [2:0] CFG_OPEN     = 3'd2;
  localparam logic [2:0] CFG_WPROT    = 3'd3;
  localparam logic [2:0] CFG_SECTORS  = 3'd4;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  typedef struct packed {
    logic       in_window;
    logic [2:0] reg_sel;
    logic       attached;
    logic       usable;
    logic       wprot;
    logic       lba_ok;
  } chk_t;

endpackage

`default_nettype wire

>>> design/sector_disk_controller_unit.sv
// Top level of the sector disk controller: bus access sequencer, sector copy
// loop and store clearing. Depends on sdc_pkg, sdc_check and sdc_ram.
//
//   channel  direction  handshake           words
//   in_      input      in_valid/in_stall   in_func, in_port, in_write_data
//   out_     output     out_valid/out_stall out_read_data, out_drq_flag, out_error_flag
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A register access goes through S_EXEC and S_DONE, a data port read through S_EXEC,
// S_RDWAIT and S_DONE. Command 1 and the last data write copy one sector byte by byte
// through the one-port-each RAMs in S_COPY. After reset the store and the sector buffer
// are filled with 0xE5, one byte per cycle through all STORE_DEPTH (131072) addresses,
// during which no word is accepted; configuration writes are taken at all times.
// A stalled result holds in the output register; the next word is accepted
// meanwhile and waits at its end for the register to free up.
`timescale 1ns / 1ps
`default_nettype none

module sector_disk_controller_unit import sdc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [15:0] in_port,
  input  wire logic [7:0]  in_write_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_read_data,
  output logic             out_drq_flag,
  output logic             out_error_flag,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_COPY   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  localparam logic [BI_W-1:0] SB = BI_W'(SECTOR_BYTES);

  // configuration
  logic [15:0] base_r;
  logic [3:0]  att_r, open_r, ro_r;
  logic [8:0]  sect_r;

  // controller state
  logic [2:0]          state_r, state_nxt;
  logic [STORE_AW-1:0] clr_r, clr_nxt;
  logic [BI_W-1:0]     cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [IDX_W-1:0]    pidx_r, pidx_nxt;
  logic                dir_r, dir_nxt;
  logic [BI_W-1:0]     idx_r, idx_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic                drq_r, drq_nxt;
  logic                err_r, err_nxt;
  logic [31:0]         lba_r, lba_nxt;
  logic [DRV_W-1:0]    drv_r, drv_nxt;

  // captured word
  logic       func_r;
  logic [7:0] wdata_r;
  logic       win_r;
  logic [2:0] sel_r;
  logic [7:0] rd_r, rd_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_rd_r;
  logic       out_drq_r, out_err_r;

  chk_t chk;
  logic in_acc, out_load;

  logic                st_we;
  logic [STORE_AW-1:0] st_waddr, st_raddr;
  logic [7:0]          st_wdata, st_rdata;
  logic                bf_we;
  logic [IDX_W-1:0]    bf_waddr, bf_raddr;
  logic [7:0]          bf_wdata, bf_rdata;

  sdc_check u_check (
    .port           (in_port),
    .win_base       (base_r),
    .drive_sel      (drv_r),
    .attached_mask  (att_r),
    .open_mask      (open_r),
    .wprot_mask     (ro_r),
    .drive_sectors  (sect_r),
    .lba            (lba_r),
    .chk            (chk)
  );

  sdc_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  sdc_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_buffer (
    .clk   (clk),
    .we    (bf_we),
    .waddr (bf_waddr),
    .wdata (bf_wdata),
    .raddr (bf_raddr),
    .rdata (bf_rdata)
  );

  assign in_stall       = (state_r != S_IDLE);
  assign in_acc         = in_valid & ~in_stall;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_read_data  = out_rd_r;
  assign out_drq_flag   = out_drq_r;
  assign out_error_flag = out_err_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    pidx_nxt  = pidx_r;
    dir_nxt   = dir_r;
    idx_nxt   = idx_r;
    mode_nxt  = mode_r;
    drq_nxt   = drq_r;
    err_nxt   = err_r;
    lba_nxt   = lba_r;
    drv_nxt   = drv_r;
    rd_nxt    = rd_r;
    out_load  = 1'b0;
    out_valid_nxt = out_valid_r & out_stall;

    st_we    = 1'b0;
    st_waddr = {drv_r, lba_r[LBA_W-1:0], pidx_r};
    st_wdata = bf_rdata;
    st_raddr = {drv_r, lba_r[LBA_W-1:0], cnt_r[IDX_W-1:0]};
    bf_we    = 1'b0;
    bf_waddr = pidx_r;
    bf_wdata = st_rdata;
    bf_raddr = cnt_r[IDX_W-1:0];

    unique case (state_r)
      S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        st_wdata = FILL_BYTE;
        bf_we    = 1'b1;
        bf_waddr = clr_r[IDX_W-1:0];
        bf_wdata = FILL_BYTE;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == STORE_AW'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        rd_nxt    = 8'h00;
        if (!win_r) begin
          if (!func_r) begin
            rd_nxt = NO_DATA;
          end
        end else if (!func_r) begin
          unique case (sel_r)
            REG_CMD:    rd_nxt = 8'h00;
            REG_STATUS: rd_nxt = (chk.attached ? ST_READY : 8'h00) |
                                 (err_r ? ST_ERR : 8'h00) | (drq_r ? ST_DRQ : 8'h00);
            REG_LBA0:   rd_nxt = lba_r[7:0];
            REG_LBA1:   rd_nxt = lba_r[15:8];
            REG_LBA2:   rd_nxt = lba_r[23:16];
            REG_LBA3:   rd_nxt = lba_r[31:24];
            REG_DATA: begin
              if (mode_r == MODE_READ && drq_r && idx_r < SB) begin
                bf_raddr  = idx_r[IDX_W-1:0];
                idx_nxt   = idx_r + 1'b1;
                state_nxt = S_RDWAIT;
                if (idx_r + 1'b1 == SB) begin
                  drq_nxt  = 1'b0;
                  mode_nxt = MODE_IDLE;
                end
              end else begin
                rd_nxt = NO_DATA;
              end
            end
            REG_DRIVE:  rd_nxt = 8'(drv_r);
            default:    rd_nxt = NO_DATA;
          endcase
        end else begin
          unique case (sel_r)
            REG_CMD: begin
              if (wdata_r == CMD_READ) begin
                if (!chk.usable || !chk.lba_ok) begin
                  err_nxt  = 1'b1;
                  drq_nxt  = 1'b0;
                  mode_nxt = MODE_IDLE;
                end else begin
                  err_nxt   = 1'b0;
                  idx_nxt   = '0;
                  mode_nxt  = MODE_READ;
                  drq_nxt   = 1'b1;
                  dir_nxt   = 1'b0;
                  cnt_nxt   = '0;
                  pend_nxt  = 1'b0;
                  state_nxt = S_COPY;
                end
              end else if (wdata_r == CMD_WRITE) begin
                if (!chk.usable || chk.wprot) begin
                  err_nxt  = 1'b1;
                  drq_nxt  = 1'b0;
                  mode_nxt = MODE_IDLE;
                end else begin
                  err_nxt  = 1'b0;
                  idx_nxt  = '0;
                  mode_nxt = MODE_WRITE;
                  drq_nxt  = 1'b1;
                end
              end else begin
                drq_nxt  = 1'b0;
                mode_nxt = MODE_IDLE;
              end
            end
            REG_LBA0:  lba_nxt[7:0]   = wdata_r;
            REG_LBA1:  lba_nxt[15:8]  = wdata_r;
            REG_LBA2:  lba_nxt[23:16] = wdata_r;
            REG_LBA3:  lba_nxt[31:24] = wdata_r;
            REG_DATA: begin
              if (mode_r == MODE_WRITE && drq_r && idx_r < SB) begin
                bf_we    = 1'b1;
                bf_waddr = idx_r[IDX_W-1:0];
                bf_wdata = wdata_r;
                idx_nxt  = idx_r + 1'b1;
                if (idx_r + 1'b1 == SB) begin
                  // last byte: commit the sector to the store if the drive and LBA checks pass
                  drq_nxt  = 1'b0;
                  mode_nxt = MODE_IDLE;
                  if (!chk.usable || chk.wprot || !chk.lba_ok) begin
                    err_nxt = 1'b1;
                  end else begin
                    dir_nxt   = 1'b1;
                    cnt_nxt   = '0;
                    pend_nxt  = 1'b0;
                    state_nxt = S_COPY;
                  end
                end
              end
            end
            REG_DRIVE: drv_nxt = DRV_W'(wdata_r & DRIVE_MASK);
            default: ;
          endcase
        end
      end

      S_RDWAIT: begin
        rd_nxt    = bf_rdata;
        state_nxt = S_DONE;
      end

      S_COPY: begin
        // read one byte per cycle and write it in the cycle after
        if (dir_r) begin
          st_we = pend_r;
        end else begin
          bf_we = pend_r;
        end
        pend_nxt = (cnt_r < SB);
        pidx_nxt = cnt_r[IDX_W-1:0];
        if (cnt_r < SB) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      dir_r       <= 1'b0;
      idx_r       <= '0;
      mode_r      <= MODE_IDLE;
      drq_r       <= 1'b0;
      err_r       <= 1'b0;
      lba_r       <= '0;
      drv_r       <= '0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      att_r       <= '0;
      open_r      <= '0;
      ro_r        <= '0;
      sect_r      <= 9'd256;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      dir_r       <= dir_nxt;
      idx_r       <= idx_nxt;
      mode_r      <= mode_nxt;
      drq_r       <= drq_nxt;
      err_r       <= err_nxt;
      lba_r       <= lba_nxt;
      drv_r       <= drv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_WIN_BASE: base_r <= cfg_data;
          CFG_ATTACHED: att_r  <= cfg_data[3:0];
          CFG_OPEN:     open_r <= cfg_data[3:0];
          CFG_WPROT:    ro_r   <= cfg_data[3:0];
          CFG_SECTORS:  sect_r <= cfg_data[8:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= pidx_nxt;
    rd_r   <= rd_nxt;
    if (in_acc) begin
      func_r  <= in_func;
      wdata_r <= in_write_data;
      win_r   <= chk.in_window;
      sel_r   <= chk.reg_sel;
    end
    if (out_load) begin
      out_rd_r  <= rd_r;
      out_drq_r <= drq_r;
      out_err_r <= err_r;
    end
  end

endmodule

`default_nettype wire

>>> design/sdc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/sdc_check.sv
// Window decode and drive/LBA checks of the sector disk controller.
// Depends on sdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdc_check import sdc_pkg::*; (
  input  wire logic [15:0]      port,
  input  wire logic [15:0]      win_base,
  input  wire logic [DRV_W-1:0] drive_sel,
  input  wire logic [3:0]       attached_mask,
  input  wire logic [3:0]       open_mask,
  input  wire logic [3:0]       wprot_mask,
  input  wire logic [8:0]       drive_sectors,
  input  wire logic [31:0]      lba,
  output chk_t                  chk
);

  logic [15:0] offset;
  logic [31:0] limit;

  always_comb begin
    offset = port - win_base;
    // saturate the sector count to what the store holds
    limit = (32'(drive_sectors) > 32'(SECTORS_PER_DRIVE)) ?
            32'(SECTORS_PER_DRIVE) : 32'(drive_sectors);
    chk.in_window = (offset[15:3] == 13'd0);
    chk.reg_sel   = offset[2:0];
    chk.attached  = attached_mask[drive_sel];
    chk.usable    = attached_mask[drive_sel] & open_mask[drive_sel];
    chk.wprot     = wprot_mask[drive_sel];
    chk.lba_ok    = (lba < limit);
  end

endmodule

`default_nettype wire

>>> bench/sdc_access_checker.sv
// Result checker for the sector disk controller: mirrors the register window,
// sector buffer and disk store, and compares every result word. Uses sdc_pkg.
`timescale 1ns / 1ps

module sdc_access_checker import sdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_func,
  input  logic [15:0] in_port,
  input  logic [7:0]  in_write_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_read_data,
  input  logic        out_drq_flag,
  input  logic        out_error_flag,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          in_flight
);

  typedef struct packed {
    logic [7:0] read_data;
    logic       drq_flag;
    logic       error_flag;
  } bus_result_t;

  bus_result_t pending_results[$];

  // configuration copy
  logic [15:0] base_q;
  logic [3:0]  att_q, open_q, ro_q;
  logic [8:0]  sectors_q;

  // controller state copy
  logic [7:0]  sbuf [SECTOR_BYTES];
  int          bidx;
  logic [1:0]  mode_q;
  logic        drq_q, err_q;
  logic [7:0]  lba_q [4];
  logic [1:0]  drv_q;
  logic [7:0]  disk_image [int];  // bytes never written read as FILL_BYTE

  function automatic logic [31:0] lba_word();
    return {lba_q[3], lba_q[2], lba_q[1], lba_q[0]};
  endfunction

  function automatic bit lba_in_range();
    logic [31:0] limit;
    limit = (sectors_q > SECTORS_PER_DRIVE) ? SECTORS_PER_DRIVE : sectors_q;
    return lba_word() < limit;
  endfunction

  function automatic bit drive_ok();
    return att_q[drv_q] && open_q[drv_q];
  endfunction

  function automatic int sector_addr();
    return (int'(drv_q) * SECTORS_PER_DRIVE + int'(lba_word())) * SECTOR_BYTES;
  endfunction

  task automatic abort_with_error();
    err_q  = 1'b1;
    drq_q  = 1'b0;
    mode_q = MODE_IDLE;
  endtask

  task automatic predict_bus_access(input logic f, input logic [15:0] p,
                                    input logic [7:0] d, output bus_result_t r);
    logic [15:0] off;
    logic [7:0]  rd;
    int          a;
    off = p - base_q;
    rd  = 8'h00;
    if (off > 16'd7) begin
      if (!f) rd = NO_DATA;
    end else if (!f) begin
      case (off[2:0])
        REG_CMD: rd = 8'h00;
        REG_STATUS: begin
          if (att_q[drv_q]) rd |= ST_READY;
          if (err_q) rd |= ST_ERR;
          if (drq_q) rd |= ST_DRQ;
        end
        REG_LBA0, REG_LBA1, REG_LBA2, REG_LBA3: rd = lba_q[2'(off[2:0] - REG_LBA0)];
        REG_DATA: begin
          if (mode_q != MODE_READ || !drq_q || bidx >= SECTOR_BYTES) begin
            rd = NO_DATA;
          end else begin
            rd = sbuf[bidx];
            bidx++;
            if (bidx >= SECTOR_BYTES) begin
              drq_q  = 1'b0;
              mode_q = MODE_IDLE;
            end
          end
        end
        default: rd = {6'b0, drv_q};
      endcase
    end else begin
      case (off[2:0])
        REG_CMD: begin
          if (d == CMD_READ) begin
            err_q = 1'b0;
            if (!drive_ok() || !lba_in_range()) begin
              abort_with_error();
            end else begin
              a = sector_addr();
              for (int i = 0; i < SECTOR_BYTES; i++)
                sbuf[i] = disk_image.exists(a + i) ? disk_image[a + i] : FILL_BYTE;
              bidx   = 0;
              mode_q = MODE_READ;
              drq_q  = 1'b1;
            end
          end else if (d == CMD_WRITE) begin
            err_q = 1'b0;
            if (!drive_ok() || ro_q[drv_q]) begin
              abort_with_error();
            end else begin
              bidx   = 0;
              mode_q = MODE_WRITE;
              drq_q  = 1'b1;
            end
          end else begin
            mode_q = MODE_IDLE;
            drq_q  = 1'b0;
          end
        end
        REG_LBA0, REG_LBA1, REG_LBA2, REG_LBA3: lba_q[2'(off[2:0] - REG_LBA0)] = d;
        REG_DATA: begin
          if (mode_q == MODE_WRITE && drq_q && bidx < SECTOR_BYTES) begin
            sbuf[bidx] = d;
            bidx++;
            // last byte: recheck drive and LBA with current settings, commit if they pass
            if (bidx >= SECTOR_BYTES) begin
              if (!drive_ok() || ro_q[drv_q] || !lba_in_range()) begin
                err_q = 1'b1;
              end else begin
                a = sector_addr();
                for (int i = 0; i < SECTOR_BYTES; i++) disk_image[a + i] = sbuf[i];
              end
              drq_q  = 1'b0;
              mode_q = MODE_IDLE;
            end
          end
        end
        REG_DRIVE: drv_q = d[1:0];
        default: ;
      endcase
    end
    r = '{rd, drq_q, err_q};
  endtask

  always @(posedge clk) begin : watch
    bus_result_t got, want, predicted;
    if (!rst_n) begin
      base_q    = 16'h0000;
      att_q     = 4'h0;
      open_q    = 4'h0;
      ro_q      = 4'h0;
      sectors_q = 9'd256;
      foreach (sbuf[i]) sbuf[i] = FILL_BYTE;
      foreach (lba_q[i]) lba_q[i] = 8'h00;
      bidx   = 0;
      mode_q = MODE_IDLE;
      drq_q  = 1'b0;
      err_q  = 1'b0;
      drv_q  = 2'd0;
      disk_image.delete();
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIN_BASE: base_q    = cfg_data;
          CFG_ATTACHED: att_q     = cfg_data[3:0];
          CFG_OPEN:     open_q    = cfg_data[3:0];
          CFG_WPROT:    ro_q      = cfg_data[3:0];
          CFG_SECTORS:  sectors_q = cfg_data[8:0];
          default: ;
        endcase
      end
      // check the result before queuing this edge's access: it cannot be its own
      if (out_valid && !out_stall) begin
        got = '{out_read_data, out_drq_flag, out_error_flag};
        if (pending_results.size() == 0) begin
          $error("result word with no access pending: %02h drq %0b err %0b",
                 got.read_data, got.drq_flag, got.error_flag);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %02h, got %02h", want.read_data, got.read_data);
            mismatch_count++;
          end
          if (got.drq_flag !== want.drq_flag) begin
            $error("drq_flag: expected %0b, got %0b", want.drq_flag, got.drq_flag);
            mismatch_count++;
          end
          if (got.error_flag !== want.error_flag) begin
            $error("error_flag: expected %0b, got %0b", want.error_flag, got.error_flag);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_bus_access(in_func, in_port, in_write_data, predicted);
        pending_results.push_back(predicted);
      end
    end
    in_flight <= pending_results.size();
  end

endmodule

>>> bench/sector_disk_controller_unit_tb.sv
// Testbench top for sector_disk_controller_unit: clock, reset, bus stimulus,
// output stall pattern and verdict. Depends on sdc_pkg and sdc_access_checker.
`timescale 1ns / 1ps

module sector_disk_controller_unit_tb;
  import sdc_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_WORDS = 130;
  localparam int LONG_HOLD   = 400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [15:0] in_port;
  logic [7:0]  in_write_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_drq_flag;
  logic        out_error_flag;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int          mismatch_count;
  int          in_flight;
  int unsigned cycles = 0;

  // stimulus-side view of the settings
  logic [15:0] base_cur = 16'h0000;
  logic [8:0]  sectors_cur = 9'd256;
  int          burst_left = 0;
  int          words_sent = 0;
  bit          gapless = 1'b0;
  bit          upper_dirty = 1'b0;
  logic        hold_off_req = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;

  sector_disk_controller_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_port        (in_port),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_drq_flag   (out_drq_flag),
    .out_error_flag (out_error_flag),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  sdc_access_checker access_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_port        (in_port),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_drq_flag   (out_drq_flag),
    .out_error_flag (out_error_flag),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .in_flight      (in_flight)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: one long hold-off on request, otherwise a pattern selected by cycle
  // counter bits 9:8
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_off_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      case (cycles[9:8])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 99) < 25);
        2'd2: out_stall <= ($urandom_range(0, 99) < 70);
        default: out_stall <= cycles[1];
      endcase
    end
  end

  function automatic logic [15:0] win(input int off);
    return 16'(int'(base_cur) + off);
  endfunction

  function automatic logic [7:0] pick_lba();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 8'($urandom_range(0, 3));
      6: return 8'(sectors_cur - 9'd1);
      7: return 8'(sectors_cur);
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic f, input logic [15:0] p, input logic [7:0] d);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_func       <= f;
    in_port       <= p;
    in_write_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // unused upper bits of cfg_data carry junk
  task automatic configure(input logic [15:0] base, input logic [3:0] att,
                           input logic [3:0] opn, input logic [3:0] ro,
                           input logic [8:0] sectors);
    write_reg(CFG_WIN_BASE, base);
    write_reg(CFG_ATTACHED, {12'($urandom), att});
    write_reg(CFG_OPEN, {12'($urandom), opn});
    write_reg(CFG_WPROT, {12'($urandom), ro});
    write_reg(CFG_SECTORS, {7'($urandom), sectors});
    cfg_valid   <= 1'b0;
    base_cur    = base;
    sectors_cur = sectors;
  endtask

  // hold the input idle until every result is back, then let a sector copy finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (SECTOR_BYTES + 16) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic aim_transfer();
    logic [7:0] v;
    send_word(1'b1, win(REG_DRIVE), 8'($urandom));
    if (upper_dirty || $urandom_range(0, 4) == 0) begin
      upper_dirty = 1'b0;
      for (int j = 0; j < 3; j++) begin
        v = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'h00;
        if (v != 8'h00) upper_dirty = 1'b1;
        send_word(1'b1, win(REG_LBA1 + j), v);
      end
    end
    send_word(1'b1, win(REG_LBA0), pick_lba());
  endtask

  task automatic poke_one();
    case ($urandom_range(0, 3))
      0: send_word(1'b0, win(REG_STATUS), 8'($urandom));
      1: send_word(1'b1, win(REG_LBA0), pick_lba());
      2: send_word(1'b1, win(REG_DRIVE), 8'($urandom));
      default: send_word(1'($urandom), win($urandom_range(0, 7)), 8'($urandom));
    endcase
  endtask

  task automatic poke_registers();
    int n;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1: send_word(1'($urandom), win($urandom_range(8, 15)), 8'($urandom));
        2: send_word(1'($urandom), 16'($urandom), 8'($urandom));
        default: send_word(1'($urandom), win($urandom_range(0, 7)), 8'($urandom));
      endcase
    end
  endtask

  task automatic abort_transfer();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CMD_READ || c == CMD_WRITE);
    send_word(1'b1, win(REG_CMD), c);
  endtask

  task automatic write_sector();
    int n;
    aim_transfer();
    send_word(1'b1, win(REG_CMD), CMD_WRITE);
    n = ($urandom_range(0, 9) < 6) ? SECTOR_BYTES + $urandom_range(0, 2)
                                    : $urandom_range(0, SECTOR_BYTES - 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3) poke_one();
      send_word(1'b1, win(REG_DATA), 8'($urandom));
    end
    if (n < SECTOR_BYTES && $urandom_range(0, 1) == 1) abort_transfer();
  endtask

  task automatic read_sector();
    int n;
    aim_transfer();
    send_word(1'b1, win(REG_CMD), CMD_READ);
    n = ($urandom_range(0, 9) < 5) ? SECTOR_BYTES + $urandom_range(0, 2)
                                    : $urandom_range(0, SECTOR_BYTES - 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 4) poke_one();
      send_word(1'b0, win(REG_DATA), 8'($urandom));
    end
    if (n < SECTOR_BYTES && $urandom_range(0, 1) == 1) abort_transfer();
  endtask

  initial begin
    int phase_end;
    int roll;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_func       = 1'b0;
    in_port       = 16'h0000;
    in_write_data = 8'h00;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_WIN_BASE;
    cfg_data      = 16'h0000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // drive 0 usable, 1 read-only, 2 attached but closed, 3 absent; window wraps
    configure(16'hFFFC, 4'b0111, 4'b0011, 4'b0010, 9'd2);
    send_word(1'b0, win(REG_STATUS), 8'($urandom));
    send_word(1'b1, win(REG_LBA0), 8'hFF);
    send_word(1'b1, win(REG_LBA3), 8'h80);
    send_word(1'b0, win(REG_LBA0), 8'($urandom));
    send_word(1'b1, win(REG_CMD), CMD_READ);
    send_word(1'b1, win(REG_LBA0), 8'h01);
    send_word(1'b1, win(REG_LBA3), 8'h00);
    send_word(1'b1, win(REG_CMD), CMD_READ);
    send_word(1'b0, win(REG_DATA), 8'($urandom));
    send_word(1'b1, win(REG_DATA), 8'h5A);
    send_word(1'b0, win(REG_DATA), 8'($urandom));
    send_word(1'b1, win(REG_CMD), 8'hFF);
    send_word(1'b0, win(REG_DATA), 8'($urandom));
    send_word(1'b1, win(REG_DRIVE), 8'hFD);
    send_word(1'b1, win(REG_CMD), CMD_WRITE);
    send_word(1'b0, win(REG_STATUS), 8'($urandom));
    send_word(1'b1, win(REG_DRIVE), 8'h02);
    send_word(1'b1, win(REG_CMD), CMD_READ);
    send_word(1'b1, win(REG_DRIVE), 8'h03);
    send_word(1'b0, win(REG_STATUS), 8'($urandom));
    send_word(1'b0, win(8), 8'($urandom));
    send_word(1'b1, win(16'h8000), 8'hA5);
    send_word(1'b1, win(REG_DRIVE), 8'h00);
    send_word(1'b1, win(REG_CMD), CMD_WRITE);
    send_word(1'b1, win(REG_CMD), 8'h00);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: configure(16'h01F0, 4'hF, 4'hF, 4'h0, 9'd256);
        1: configure(16'h0000, 4'hF, 4'hF, 4'b1010, 9'd511);
        2: configure(16'hFFFF, 4'h0, 4'hF, 4'hF, 9'd0);
        3: configure(16'($urandom), 4'hF, 4'hF, 4'h0, 9'd1);
        4: configure(16'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                     9'($urandom_range(0, 511)));
        default: configure(16'hFFF8, 4'b1001, 4'b1101, 4'b0100, 9'd3);
      endcase
      if (ph == 1) begin
        // offer words back to back while the receiver holds off: fill the block
        hold_off_req <= 1'b1;
        gapless = 1'b1;
        repeat (80) send_word(1'b0, win($urandom_range(1, 5)), 8'($urandom));
        gapless = 1'b0;
      end
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 40) write_sector();
        else if (roll < 75) read_sector();
        else poke_registers();
      end
    end

    drain();
    if (mismatch_count == 0 && in_flight == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
